// ----- design/lcdws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble write sequencer - shared package
// Item kinds, queue sizing, register indexes and the power-up command table.
// ----------------------------------------------------------------------------
package lcdws_pkg;

	// Opcodes on the input channel
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_WR_CMD   = 2'd1;
	localparam logic [1:0] OP_WR_DATA  = 2'd2;
	localparam logic [1:0] OP_RUN_INIT = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PHASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP     = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  ENABLE_PHASE_RST = 8'd10;
	localparam logic [15:0] BYTE_GAP_RST     = 16'd100;
	localparam logic [15:0] INIT_GAP_RST     = 16'd10000;

	// Decoupling queue: depth must be a power of two
	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

	// Power-up sequence
	localparam logic [3:0] INIT_LEN = 4'd10;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_WRITE,
		KIND_INIT
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic       rs;
		logic [7:0] data;
	} item_t;

	function automatic logic [7:0] init_cmd(input logic [3:0] idx);
		logic [7:0] cmd;
		unique case (idx)
			4'd0:    cmd = 8'h30;
			4'd1:    cmd = 8'h30;
			4'd2:    cmd = 8'h30;
			4'd3:    cmd = 8'h20;
			4'd4:    cmd = 8'h28;
			4'd5:    cmd = 8'h06;
			4'd6:    cmd = 8'h01;
			4'd7:    cmd = 8'h02;
			4'd8:    cmd = 8'h08;
			4'd9:    cmd = 8'h0F;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

// ----- design/lcdws_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble write sequencer - front end
// Decodes incoming transfers into items and queues them for the sequencer.
// ----------------------------------------------------------------------------
module lcdws_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // [7:0] value
	input  logic [1:0]          s_tuser,  // [1:0] op
	output logic                item_valid,
	output lcdws_pkg::item_t    item,
	input  logic                item_pop
);

	lcdws_pkg::item_t                   queue_q [lcdws_pkg::QUEUE_DEPTH];
	logic [lcdws_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [lcdws_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [lcdws_pkg::QUEUE_AW:0]       count_q;
	lcdws_pkg::item_t                   dec;
	logic                               push;

	// Classify: init request carries its first command already
	always_comb begin
		dec.rs   = 1'b0;
		dec.data = s_tdata;
		unique case (s_tuser)
			lcdws_pkg::OP_TICK:     dec.kind = lcdws_pkg::KIND_TICK;
			lcdws_pkg::OP_WR_CMD:   dec.kind = lcdws_pkg::KIND_WRITE;
			lcdws_pkg::OP_WR_DATA: begin
				dec.kind = lcdws_pkg::KIND_WRITE;
				dec.rs   = 1'b1;
			end
			lcdws_pkg::OP_RUN_INIT: begin
				dec.kind = lcdws_pkg::KIND_INIT;
				dec.data = lcdws_pkg::init_cmd(4'd0);
			end
			default:                dec.kind = lcdws_pkg::KIND_TICK;
		endcase
	end

	assign s_tready   = (count_q != (lcdws_pkg::QUEUE_AW+1)'(lcdws_pkg::QUEUE_DEPTH));
	assign push       = s_tvalid && s_tready;
	assign item_valid = (count_q != '0);
	assign item       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, item_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/lcdws_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble write sequencer - back end
// Phase sequencer for nibble strobes, gaps and power-up, plus result register.
// ----------------------------------------------------------------------------
module lcdws_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lcdws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcdws_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 item_valid,
	input  lcdws_pkg::item_t                     item,
	output logic                                 item_pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_EN_LOW1,
		PH_EN_HIGH,
		PH_EN_LOW2,
		PH_BYTE_GAP,
		PH_INIT_GAP
	} phase_t;

	// Configuration
	logic [7:0]  en_phase_q;
	logic [15:0] byte_gap_q;
	logic [15:0] init_gap_q;

	// Sequencer state
	phase_t      phase_q, phase_d;
	logic        low_q, low_d;
	logic [15:0] cnt_q, cnt_d;
	logic [3:0]  idx_q, idx_d;
	logic        run_q, run_d;
	logic [7:0]  held_q, held_d;
	logic        rs_q, rs_d;
	logic        e_q, e_d;
	logic [3:0]  db_q, db_d;
	logic        rej;

	// Result register
	logic        m_valid_q;
	logic [7:0]  m_data_q;

	logic        busy;
	logic [15:0] plen;
	logic [15:0] cnt_dec;
	logic [3:0]  idx_inc;
	logic        bgap_end;
	logic        igap_end;
	logic        start;
	logic        start_rs;
	logic [7:0]  start_byte;

	assign busy     = (phase_q != PH_IDLE);
	assign plen     = (en_phase_q == 8'd0) ? 16'd1 : {8'd0, en_phase_q};
	assign cnt_dec  = (cnt_q == 16'd0) ? 16'd0 : cnt_q - 16'd1;
	assign idx_inc  = idx_q + 4'd1;
	assign item_pop = item_valid && (!m_valid_q || m_tready);

	always_comb begin
		phase_d    = phase_q;
		low_d      = low_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		run_d      = run_q;
		held_d     = held_q;
		rs_d       = rs_q;
		e_d        = e_q;
		db_d       = db_q;
		rej        = 1'b0;
		bgap_end   = 1'b0;
		igap_end   = 1'b0;
		start      = 1'b0;
		start_rs   = 1'b0;
		start_byte = 8'd0;

		if (item.kind == lcdws_pkg::KIND_TICK) begin
			if (busy) begin
				cnt_d = cnt_dec;
				if (cnt_dec == 16'd0) begin
					unique case (phase_q)
						PH_EN_LOW1: begin
							phase_d = PH_EN_HIGH;
							e_d     = 1'b1;
							cnt_d   = plen;
						end
						PH_EN_HIGH: begin
							phase_d = PH_EN_LOW2;
							e_d     = 1'b0;
							cnt_d   = plen;
						end
						PH_EN_LOW2: begin
							if (!low_q) begin
								low_d   = 1'b1;
								db_d    = held_q[3:0];
								phase_d = PH_EN_LOW1;
								cnt_d   = plen;
							end else if (byte_gap_q != 16'd0) begin
								phase_d = PH_BYTE_GAP;
								cnt_d   = byte_gap_q;
							end else begin
								bgap_end = 1'b1;
							end
						end
						PH_BYTE_GAP: bgap_end = 1'b1;
						PH_INIT_GAP: igap_end = 1'b1;
						default: begin
							phase_d = PH_IDLE;
							cnt_d   = 16'd0;
						end
					endcase
				end
			end
		end else if (busy) begin
			rej = 1'b1;
		end else begin
			start      = 1'b1;
			start_rs   = item.rs;
			start_byte = item.data;
			if (item.kind == lcdws_pkg::KIND_INIT) begin
				run_d = 1'b1;
				idx_d = 4'd0;
			end
		end

		// End of byte gap: on to the init gap, or done
		if (bgap_end) begin
			if (run_q) begin
				if (init_gap_q != 16'd0) begin
					phase_d = PH_INIT_GAP;
					cnt_d   = init_gap_q;
				end else begin
					igap_end = 1'b1;
				end
			end else begin
				phase_d = PH_IDLE;
				cnt_d   = 16'd0;
			end
		end

		// End of init gap: next power-up command, or sequence complete
		if (igap_end) begin
			if (idx_inc < lcdws_pkg::INIT_LEN) begin
				idx_d      = idx_inc;
				start      = 1'b1;
				start_rs   = 1'b0;
				start_byte = lcdws_pkg::init_cmd(idx_inc);
			end else begin
				run_d   = 1'b0;
				idx_d   = 4'd0;
				phase_d = PH_IDLE;
				cnt_d   = 16'd0;
			end
		end

		// Byte start: RS and high nibble with E low
		if (start) begin
			held_d  = start_byte;
			rs_d    = start_rs;
			low_d   = 1'b0;
			db_d    = start_byte[7:4];
			e_d     = 1'b0;
			phase_d = PH_EN_LOW1;
			cnt_d   = plen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_phase_q <= lcdws_pkg::ENABLE_PHASE_RST;
			byte_gap_q <= lcdws_pkg::BYTE_GAP_RST;
			init_gap_q <= lcdws_pkg::INIT_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcdws_pkg::CFG_ENABLE_PHASE: en_phase_q <= cfg_data[7:0];
				lcdws_pkg::CFG_BYTE_GAP:     byte_gap_q <= cfg_data;
				lcdws_pkg::CFG_INIT_GAP:     init_gap_q <= cfg_data;
				default:                     en_phase_q <= en_phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			low_q     <= 1'b0;
			cnt_q     <= 16'd0;
			idx_q     <= 4'd0;
			run_q     <= 1'b0;
			held_q    <= 8'd0;
			rs_q      <= 1'b0;
			e_q       <= 1'b0;
			db_q      <= 4'd0;
			m_valid_q <= 1'b0;
			m_data_q  <= 8'd0;
		end else begin
			if (item_pop) begin
				phase_q   <= phase_d;
				low_q     <= low_d;
				cnt_q     <= cnt_d;
				idx_q     <= idx_d;
				run_q     <= run_d;
				held_q    <= held_d;
				rs_q      <= rs_d;
				e_q       <= e_d;
				db_q      <= db_d;
				m_valid_q <= 1'b1;
				m_data_q  <= {rej, (phase_d != PH_IDLE), db_d, e_d, rs_d};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ----- design/char_lcd_nibble_write_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD 4-bit write sequencer - top level
// Runs command/data byte writes and the power-up sequence on a 4-bit
// display bus, timed by microsecond tick items; one pin snapshot per item.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                                   | transfer
//  ---------+-----------+-------------------------------------------+-------------------
//  s_*      | in        | tuser[1:0] op, tdata[7:0] value            | s_tvalid & s_tready
//  m_*      | out       | tdata: rs, enable, data[3:0], busy, reject | m_tvalid & m_tready
//  cfg_*    | in        | cfg_index selects register, cfg_data value | cfg_we
//
//  - One item per cycle sustained while m_tready holds; m_tvalid rises after
//    the input transfer passes the queue write and then the sequencer step
//    into the result reg.
//  - Every item, tick or request, is one step of the phase sequencer: a busy
//    tick is a counter decrement plus up to three chained phase changes.
//  - A four-entry queue parts the decoder from the sequencer, so the input
//    keeps taking transfers while a result waits on m_tready, until it fills.
//  - arst_n clears the queue, the sequencer (idle, pins low) and restores the
//    timing registers to 10 / 100 / 10000 ticks. No clearing pass.
//
module char_lcd_nibble_write_sequencer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,   // [7:0] value
	input  logic [1:0]                           s_tuser,   // [1:0] op
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata,   // [0] rs_pin, [1] enable_pin,
	                                                         // [5:2] data_pins, [6] busy_res,
	                                                         // [7] rejected
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [lcdws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcdws_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic             item_valid;
	logic             item_pop;
	lcdws_pkg::item_t item;

	// Decode and queue
	lcdws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// Phase sequencer and result register
	lcdws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ----- design/lcdws_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD nibble write sequencer - port checker
// Watches the top-level ports for stream and pin-level consistency.
// ----------------------------------------------------------------------------
module lcdws_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata
);

	// Result held steady while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Enable strobe only while busy
	a_e_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[6])
		else $error("enable high while idle");

	// A rejected request only happens while busy
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[6])
		else $error("reject reported while idle");

	// No results during reset
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind char_lcd_nibble_write_sequencer_unit lcdws_checker u_lcdws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
